// ----- rtl/vpcn_pkg.sv -----
// Shared types and codes for the vector path command normalizer.
`default_nettype none

package vpcn_pkg;

  typedef enum logic [3:0] {
    OpMove        = 4'd0,
    OpLine        = 4'd1,
    OpHorizontal  = 4'd2,
    OpVertical    = 4'd3,
    OpCubic       = 4'd4,
    OpSmoothCubic = 4'd5,
    OpQuad        = 4'd6,
    OpSmoothQuad  = 4'd7,
    OpArc         = 4'd8,
    OpClose       = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    SegStart = 3'd0,
    SegLine  = 3'd1,
    SegCubic = 3'd2,
    SegArc   = 3'd3,
    SegClose = 3'd4
  } seg_kind_e;

  typedef enum logic [1:0] {
    ClsOther = 2'd0,
    ClsCubic = 2'd1,
    ClsQuad  = 2'd2
  } curve_cls_e;

  // An arc flag argument counts as set when it equals 1.0 in Q16.16.
  localparam logic [31:0] FlagOne = 32'h0001_0000;

  typedef struct packed {
    seg_kind_e          kind;
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] c1_x;
    logic signed [31:0] c1_y;
    logic signed [31:0] c2_x;
    logic signed [31:0] c2_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] rad_x;
    logic signed [31:0] rad_y;
    logic [1:0]         flags;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/vector_path_command_normalizer.sv -----
// A result is registered in the output register, or in the skid register when the output stalls.
// Throughput: one command beat per cycle; a skid register holds one result while the output
// is stalled, so the input stalls only once that skid register is full.
// Unknown operation codes are accepted and produce no result.
// Reset clears the pen, figure start, saved control point, curve class and both valid flags;
// result payload registers are not reset.
`default_nettype none

module vector_path_command_normalizer #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [3:0]         operation_i,
  input  wire logic               relative_i,
  input  wire logic signed [31:0] arg0_i,
  input  wire logic signed [31:0] arg1_i,
  input  wire logic signed [31:0] arg2_i,
  input  wire logic signed [31:0] arg3_i,
  input  wire logic signed [31:0] arg4_i,
  input  wire logic signed [31:0] arg5_i,
  input  wire logic signed [31:0] arg6_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              segment_kind_o,
  output logic signed [31:0]      from_x_o,
  output logic signed [31:0]      from_y_o,
  output logic signed [31:0]      first_ctrl_x_o,
  output logic signed [31:0]      first_ctrl_y_o,
  output logic signed [31:0]      second_ctrl_x_o,
  output logic signed [31:0]      second_ctrl_y_o,
  output logic signed [31:0]      end_x_o,
  output logic signed [31:0]      end_y_o,
  output logic signed [31:0]      arc_radius_x_o,
  output logic signed [31:0]      arc_radius_y_o,
  output logic [1:0]              arc_flags_o
);
  import vpcn_pkg::*;

  localparam int CW = COORD_WIDTH;
  // Width that holds a pen coordinate plus a 32-bit offset without overflow.
  localparam int AW = (CW > 32) ? CW + 1 : 33;
  // Width that holds 2*pen - saved exactly.
  localparam int MW = CW + 2;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CMax = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMin = {1'b1, {(CW-1){1'b0}}};

  function automatic coord_t sat_a(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'(CMax);
    lo = AW'(CMin);
    if (v > hi) begin
      return CMax;
    end else if (v < lo) begin
      return CMin;
    end
    return CW'(v);
  endfunction

  function automatic coord_t coord(input logic signed [31:0] arg, input logic rel,
                                   input coord_t base);
    logic signed [AW-1:0] sum;
    sum = (rel ? AW'(base) : AW'(0)) + AW'(arg);
    return sat_a(sum);
  endfunction

  function automatic coord_t mirror(input coord_t p, input coord_t s);
    logic signed [MW-1:0] v;
    logic signed [MW-1:0] hi;
    logic signed [MW-1:0] lo;
    v  = (MW'(p) <<< 1) - MW'(s);
    hi = MW'(CMax);
    lo = MW'(CMin);
    if (v > hi) begin
      return CMax;
    end else if (v < lo) begin
      return CMin;
    end
    return CW'(v);
  endfunction

  coord_t     pen_x_q, pen_y_q, fig_x_q, fig_y_q, saved_x_q, saved_y_q;
  coord_t     pen_x_d, pen_y_d, fig_x_d, fig_y_d, saved_x_d, saved_y_d;
  curve_cls_e cls_q, cls_d;

  coord_t     c1x, c1y, c2x, c2y, ex, ey, rx, ry;
  seg_kind_e  kind;
  logic [1:0] flags;
  logic       op_known;

  logic       in_accept;
  logic       res_valid;
  logic       out_ready;
  result_t    res;
  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign res_valid  = in_accept && op_known;
  assign out_ready  = !out_valid_q || !out_stall_i;

  always_comb begin
    kind      = SegLine;
    c1x       = '0;
    c1y       = '0;
    c2x       = '0;
    c2y       = '0;
    ex        = pen_x_q;
    ey        = pen_y_q;
    rx        = '0;
    ry        = '0;
    flags     = 2'b00;
    cls_d     = ClsOther;
    op_known  = 1'b1;
    fig_x_d   = fig_x_q;
    fig_y_d   = fig_y_q;
    saved_x_d = saved_x_q;
    saved_y_d = saved_y_q;
    case (operation_i)
      OpMove: begin
        kind    = SegStart;
        ex      = coord(arg0_i, relative_i, pen_x_q);
        ey      = coord(arg1_i, relative_i, pen_y_q);
        fig_x_d = ex;
        fig_y_d = ey;
      end
      OpLine: begin
        ex = coord(arg0_i, relative_i, pen_x_q);
        ey = coord(arg1_i, relative_i, pen_y_q);
      end
      OpHorizontal: begin
        ex = coord(arg0_i, relative_i, pen_x_q);
      end
      OpVertical: begin
        ey = coord(arg0_i, relative_i, pen_y_q);
      end
      OpCubic: begin
        kind      = SegCubic;
        cls_d     = ClsCubic;
        c1x       = coord(arg0_i, relative_i, pen_x_q);
        c1y       = coord(arg1_i, relative_i, pen_y_q);
        c2x       = coord(arg2_i, relative_i, pen_x_q);
        c2y       = coord(arg3_i, relative_i, pen_y_q);
        ex        = coord(arg4_i, relative_i, pen_x_q);
        ey        = coord(arg5_i, relative_i, pen_y_q);
        saved_x_d = c2x;
        saved_y_d = c2y;
      end
      OpSmoothCubic: begin
        kind  = SegCubic;
        cls_d = ClsCubic;
        if (cls_q == ClsCubic) begin
          c1x = mirror(pen_x_q, saved_x_q);
          c1y = mirror(pen_y_q, saved_y_q);
        end else begin
          c1x = pen_x_q;
          c1y = pen_y_q;
        end
        c2x       = coord(arg0_i, relative_i, pen_x_q);
        c2y       = coord(arg1_i, relative_i, pen_y_q);
        ex        = coord(arg2_i, relative_i, pen_x_q);
        ey        = coord(arg3_i, relative_i, pen_y_q);
        saved_x_d = c2x;
        saved_y_d = c2y;
      end
      OpQuad: begin
        kind      = SegCubic;
        cls_d     = ClsQuad;
        c1x       = coord(arg0_i, relative_i, pen_x_q);
        c1y       = coord(arg1_i, relative_i, pen_y_q);
        c2x       = c1x;
        c2y       = c1y;
        ex        = coord(arg2_i, relative_i, pen_x_q);
        ey        = coord(arg3_i, relative_i, pen_y_q);
        saved_x_d = c1x;
        saved_y_d = c1y;
      end
      OpSmoothQuad: begin
        kind  = SegCubic;
        cls_d = ClsQuad;
        if (cls_q == ClsQuad) begin
          c1x = mirror(pen_x_q, saved_x_q);
          c1y = mirror(pen_y_q, saved_y_q);
        end else begin
          c1x = pen_x_q;
          c1y = pen_y_q;
        end
        c2x       = c1x;
        c2y       = c1y;
        ex        = coord(arg0_i, relative_i, pen_x_q);
        ey        = coord(arg1_i, relative_i, pen_y_q);
        saved_x_d = c1x;
        saved_y_d = c1y;
      end
      OpArc: begin
        kind     = SegArc;
        rx       = coord(arg0_i, 1'b0, '0);
        ry       = coord(arg1_i, 1'b0, '0);
        flags[0] = (arg3_i == FlagOne);
        flags[1] = (arg4_i == FlagOne);
        ex       = coord(arg5_i, relative_i, pen_x_q);
        ey       = coord(arg6_i, relative_i, pen_y_q);
      end
      OpClose: begin
        kind    = SegClose;
        ex      = fig_x_q;
        ey      = fig_y_q;
        fig_x_d = '0;
        fig_y_d = '0;
      end
      default: begin
        op_known = 1'b0;
      end
    endcase
    pen_x_d = ex;
    pen_y_d = ey;
  end

  // Outputs carry the low 32 bits of each coordinate, sign-extended when coordinates are narrower.
  always_comb begin
    res.kind   = kind;
    res.from_x = 32'(pen_x_q);
    res.from_y = 32'(pen_y_q);
    res.c1_x   = 32'(c1x);
    res.c1_y   = 32'(c1y);
    res.c2_x   = 32'(c2x);
    res.c2_y   = 32'(c2y);
    res.end_x  = 32'(ex);
    res.end_y  = 32'(ey);
    res.rad_x  = 32'(rx);
    res.rad_y  = 32'(ry);
    res.flags  = flags;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      fig_x_q   <= '0;
      fig_y_q   <= '0;
      saved_x_q <= '0;
      saved_y_q <= '0;
      cls_q     <= ClsOther;
    end else if (res_valid) begin
      pen_x_q   <= pen_x_d;
      pen_y_q   <= pen_y_d;
      fig_x_q   <= fig_x_d;
      fig_y_q   <= fig_y_d;
      saved_x_q <= saved_x_d;
      saved_y_q <= saved_y_d;
      cls_q     <= cls_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segment_kind_o  = out_q.kind;
  assign from_x_o        = out_q.from_x;
  assign from_y_o        = out_q.from_y;
  assign first_ctrl_x_o  = out_q.c1_x;
  assign first_ctrl_y_o  = out_q.c1_y;
  assign second_ctrl_x_o = out_q.c2_x;
  assign second_ctrl_y_o = out_q.c2_y;
  assign end_x_o         = out_q.end_x;
  assign end_y_o         = out_q.end_y;
  assign arc_radius_x_o  = out_q.rad_x;
  assign arc_radius_y_o  = out_q.rad_y;
  assign arc_flags_o     = out_q.flags;

  // The skid register only fills behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register is empty");

  a_stalled_result_skids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("result produced during output stall was not kept");

  a_close_clears_figure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && operation_i == OpClose) |=>
      (fig_x_q == '0 && fig_y_q == '0 && cls_q == ClsOther))
    else $error("close did not clear figure start and curve class");

  a_move_sets_figure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && operation_i == OpMove) |=>
      (fig_x_q == pen_x_q && fig_y_q == pen_y_q && cls_q == ClsOther))
    else $error("move did not place figure start at the new pen");

  a_unknown_holds_pen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !op_known) |=> ($stable(pen_x_q) && $stable(pen_y_q) && $stable(cls_q)))
    else $error("unknown operation changed the pen state");

endmodule

`default_nettype wire
